[hdl/u8san_pkg.sv]
// Shared types and constants for the UTF-8 validating sanitizer.
package u8san_pkg;

   localparam int MAX_RESULTS = 6;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [1:0] KIND_BYTE  = 2'd0;
   localparam logic [1:0] KIND_ERROR = 2'd1;
   localparam logic [1:0] KIND_END   = 2'd2;

   localparam logic CSR_FATAL_MODE = 1'b0;
   localparam logic CSR_IGNORE_BOM = 1'b1;

   localparam logic [7:0] REPL_0 = 8'hEF;
   localparam logic [7:0] REPL_1 = 8'hBF;
   localparam logic [7:0] REPL_2 = 8'hBD;
   localparam logic [7:0] BOM_0  = 8'hEF;
   localparam logic [7:0] BOM_1  = 8'hBB;
   localparam logic [7:0] BOM_2  = 8'hBF;

   localparam logic [7:0] ASCII_LIMIT = 8'h80;
   localparam logic [7:0] LEAD_MIN    = 8'hC2;
   localparam logic [7:0] LEAD_LIMIT  = 8'hF5;
   localparam logic [7:0] LEAD3_MIN   = 8'hE0;
   localparam logic [7:0] LEAD4_MIN   = 8'hF0;
   localparam logic [7:0] LEAD_E0     = 8'hE0;
   localparam logic [7:0] LEAD_ED     = 8'hED;
   localparam logic [7:0] LEAD_F0     = 8'hF0;
   localparam logic [7:0] LEAD_F4     = 8'hF4;

   localparam logic [2:0] RANGE_ANY = 3'd0;
   localparam logic [2:0] RANGE_E0  = 3'd1;
   localparam logic [2:0] RANGE_ED  = 3'd2;
   localparam logic [2:0] RANGE_F0  = 3'd3;
   localparam logic [2:0] RANGE_F4  = 3'd4;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data;
   } result_type;

   // One accepted item's results, in order.
   typedef struct packed {
      logic [2:0]                         count;
      result_type [MAX_RESULTS-1:0]       ent;
   } cmd_type;

   // Allowed range of a continuation byte.
   function automatic logic cont_ok(logic [2:0] ridx, logic [7:0] b);
      logic ok;
      case (ridx)
         RANGE_E0: ok = (b >= 8'hA0) && (b <= 8'hBF);
         RANGE_ED: ok = (b >= 8'h80) && (b <= 8'h9F);
         RANGE_F0: ok = (b >= 8'h90) && (b <= 8'hBF);
         RANGE_F4: ok = (b >= 8'h80) && (b <= 8'h8F);
         default:  ok = (b >= 8'h80) && (b <= 8'hBF);
      endcase
      return ok;
   endfunction

   function automatic cmd_type add_result(cmd_type c, logic [1:0] k, logic [7:0] d);
      cmd_type r;
      r = c;
      r.ent[r.count] = '{kind: k, data: d};
      r.count = r.count + 3'd1;
      return r;
   endfunction

endpackage

[hdl/u8san_if.sv]
// Channel interfaces for the request and response streams.
interface u8san_req_if;
   logic       valid;
   logic       ready;
   logic       mode;
   logic [7:0] byte_in;
   modport source (output valid, output mode, output byte_in, input ready);
   modport sink (input valid, input mode, input byte_in, output ready);
endinterface

interface u8san_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] byte_out;
   logic       last;
   modport source (output valid, output kind, output byte_out, output last, input ready);
   modport sink (input valid, input kind, input byte_out, input last, output ready);
endinterface

[hdl/u8san_front.sv]
// Front end: accepts bytes, tracks sequence state and builds result lists.
module u8san_front import u8san_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_we,
   input  logic          csr_index,
   input  logic          csr_wdata,
   u8san_req_if.sink     req_chan,
   output logic          push_valid,
   output cmd_type       push_cmd,
   input  logic          push_ready
);

   logic       fatal_mode_ff, fatal_mode_in;
   logic       ignore_bom_ff, ignore_bom_in;
   logic [7:0] held_bytes_ff [0:2];
   logic [7:0] held_bytes_in [0:2];
   logic [1:0] held_count_ff, held_count_in;
   logic [2:0] need_length_ff, need_length_in;
   logic [2:0] sri_ff, sri_in;
   logic       at_start_ff, at_start_in;
   logic       error_drop_ff, error_drop_in;

   logic       accept;
   logic       do_lead;
   logic [2:0] ridx;
   logic [7:0] b;
   cmd_type    cmd;

   assign req_chan.ready = push_ready;
   assign accept = req_chan.valid && push_ready;
   assign b = req_chan.byte_in;
   assign ridx = (held_count_ff == 2'd1) ? sri_ff : RANGE_ANY;

   always_comb begin
      fatal_mode_in = fatal_mode_ff;
      ignore_bom_in = ignore_bom_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_FATAL_MODE: fatal_mode_in = csr_wdata;
            CSR_IGNORE_BOM: ignore_bom_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      cmd = '0;
      do_lead = 1'b0;
      held_bytes_in = held_bytes_ff;
      held_count_in = held_count_ff;
      need_length_in = need_length_ff;
      sri_in = sri_ff;
      at_start_in = at_start_ff;
      error_drop_in = error_drop_ff;
      if (req_chan.mode) begin
         // end of stream: flush a partial sequence, then the end marker
         if (held_count_ff != 2'd0 && !error_drop_ff) begin
            if (fatal_mode_ff) begin
               cmd = add_result(cmd, KIND_ERROR, 8'h00);
            end else begin
               cmd = add_result(cmd, KIND_BYTE, REPL_0);
               cmd = add_result(cmd, KIND_BYTE, REPL_1);
               cmd = add_result(cmd, KIND_BYTE, REPL_2);
            end
         end
         cmd = add_result(cmd, KIND_END, 8'h00);
         held_count_in = 2'd0;
         need_length_in = 3'd0;
         sri_in = RANGE_ANY;
         at_start_in = 1'b1;
         error_drop_in = 1'b0;
      end else if (!error_drop_ff) begin
         if (held_count_ff == 2'd0) begin
            do_lead = 1'b1;
         end else if (!cont_ok(ridx, b)) begin
            at_start_in = 1'b0;
            held_count_in = 2'd0;
            need_length_in = 3'd0;
            sri_in = RANGE_ANY;
            if (fatal_mode_ff) begin
               cmd = add_result(cmd, KIND_ERROR, 8'h00);
               error_drop_in = 1'b1;
            end else begin
               cmd = add_result(cmd, KIND_BYTE, REPL_0);
               cmd = add_result(cmd, KIND_BYTE, REPL_1);
               cmd = add_result(cmd, KIND_BYTE, REPL_2);
               do_lead = 1'b1;   // breaking byte is retried as a lead
            end
         end else if ({1'b0, held_count_ff} + 3'd1 < need_length_ff) begin
            held_bytes_in[held_count_ff] = b;
            held_count_in = held_count_ff + 2'd1;
         end else begin
            at_start_in = 1'b0;
            held_count_in = 2'd0;
            need_length_in = 3'd0;
            sri_in = RANGE_ANY;
            if (!(at_start_ff && !ignore_bom_ff && held_count_ff == 2'd2 &&
                  held_bytes_ff[0] == BOM_0 && held_bytes_ff[1] == BOM_1 && b == BOM_2)) begin
               for (int i = 0; i < 3; i++) begin
                  if (i < int'(held_count_ff)) begin
                     cmd = add_result(cmd, KIND_BYTE, held_bytes_ff[i]);
                  end
               end
               cmd = add_result(cmd, KIND_BYTE, b);
            end
         end

         if (do_lead) begin
            if (b < ASCII_LIMIT) begin
               at_start_in = 1'b0;
               cmd = add_result(cmd, KIND_BYTE, b);
            end else if (b < LEAD_MIN || b >= LEAD_LIMIT) begin
               at_start_in = 1'b0;
               held_count_in = 2'd0;
               need_length_in = 3'd0;
               sri_in = RANGE_ANY;
               if (fatal_mode_ff) begin
                  cmd = add_result(cmd, KIND_ERROR, 8'h00);
                  error_drop_in = 1'b1;
               end else begin
                  cmd = add_result(cmd, KIND_BYTE, REPL_0);
                  cmd = add_result(cmd, KIND_BYTE, REPL_1);
                  cmd = add_result(cmd, KIND_BYTE, REPL_2);
               end
            end else begin
               held_bytes_in[0] = b;
               held_count_in = 2'd1;
               if (b < LEAD3_MIN) begin
                  need_length_in = 3'd2;
                  sri_in = RANGE_ANY;
               end else if (b < LEAD4_MIN) begin
                  need_length_in = 3'd3;
                  sri_in = (b == LEAD_E0) ? RANGE_E0 : (b == LEAD_ED) ? RANGE_ED : RANGE_ANY;
               end else begin
                  need_length_in = 3'd4;
                  sri_in = (b == LEAD_F0) ? RANGE_F0 : (b == LEAD_F4) ? RANGE_F4 : RANGE_ANY;
               end
            end
         end
      end
   end

   assign push_valid = accept && (cmd.count != 3'd0);
   assign push_cmd = cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         fatal_mode_ff <= 1'b0;
         ignore_bom_ff <= 1'b0;
         held_count_ff <= 2'd0;
         need_length_ff <= 3'd0;
         sri_ff <= RANGE_ANY;
         at_start_ff <= 1'b1;
         error_drop_ff <= 1'b0;
      end else begin
         fatal_mode_ff <= fatal_mode_in;
         ignore_bom_ff <= ignore_bom_in;
         if (accept) begin
            held_count_ff <= held_count_in;
            need_length_ff <= need_length_in;
            sri_ff <= sri_in;
            at_start_ff <= at_start_in;
            error_drop_ff <= error_drop_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         held_bytes_ff <= held_bytes_in;
      end
   end

`ifndef SYNTHESIS
   a_hold_below_need: assert property (@(posedge clock) disable iff (reset)
      (held_count_ff != 2'd0) |-> ({1'b0, held_count_ff} < need_length_ff))
      else $error("held count not below sequence length");
   a_drop_empty: assert property (@(posedge clock) disable iff (reset)
      error_drop_ff |-> (held_count_ff == 2'd0))
      else $error("bytes held while dropping");
   a_empty_clear: assert property (@(posedge clock) disable iff (reset)
      (held_count_ff == 2'd0) |-> (need_length_ff == 3'd0 && sri_ff == RANGE_ANY))
      else $error("sequence state left after clear");
   a_eos_pushes: assert property (@(posedge clock) disable iff (reset)
      (accept && req_chan.mode) |-> push_valid)
      else $error("end of stream produced no result");
`endif

endmodule

[hdl/u8san_queue.sv]
// Small queue of result lists between front and back.
module u8san_queue import u8san_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   input  cmd_type push_cmd,
   output logic    push_ready,
   output logic    head_valid,
   output cmd_type head_cmd,
   input  logic    pop
);

   localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CntW = $clog2(QUEUE_DEPTH + 1);

   cmd_type             mem_ff [0:QUEUE_DEPTH-1];
   logic [PtrW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]     count_ff, count_in;
   logic                do_push, do_pop;

   assign push_ready = (count_ff != CntW'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd = mem_ff[rd_ptr_ff];
   assign do_push = push_valid && push_ready;
   assign do_pop = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CntW'(do_push) - CntW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

[hdl/u8san_back.sv]
// Back end: walks each result list and drives the response register.
module u8san_back import u8san_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        head_valid,
   input  cmd_type     head_cmd,
   output logic        pop,
   u8san_rsp_if.source rsp_chan
);

   logic [2:0]  idx_ff, idx_in;
   logic        valid_ff, valid_in;
   result_type  res_ff, res_in;
   logic        last_ff, last_in;
   logic        load;
   logic        at_end;

   assign load = head_valid && (!valid_ff || rsp_chan.ready);
   assign at_end = (idx_ff == head_cmd.count - 3'd1);
   assign pop = load && at_end;

   always_comb begin
      idx_in = idx_ff;
      valid_in = valid_ff;
      res_in = res_ff;
      last_in = last_ff;
      if (load) begin
         valid_in = 1'b1;
         res_in = head_cmd.ent[idx_ff];
         last_in = at_end;
         idx_in = at_end ? 3'd0 : idx_ff + 3'd1;
      end else if (rsp_chan.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= 3'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
      last_ff <= last_in;
   end

   assign rsp_chan.valid = valid_ff;
   assign rsp_chan.kind = res_ff.kind;
   assign rsp_chan.byte_out = res_ff.data;
   assign rsp_chan.last = last_ff;

`ifndef SYNTHESIS
   a_idx_needs_head: assert property (@(posedge clock) disable iff (reset)
      (idx_ff != 3'd0) |-> head_valid)
      else $error("list index set with empty queue");
   a_idx_in_list: assert property (@(posedge clock) disable iff (reset)
      head_valid |-> (idx_ff < head_cmd.count))
      else $error("list index past result count");
   a_pop_marks_last: assert property (@(posedge clock) disable iff (reset)
      pop |=> (valid_ff && last_ff))
      else $error("list retired without last flag");
`endif

endmodule

[hdl/utf8_validating_sanitizer.sv]
// UTF-8 validating sanitizer: top level joining front end, queue and back end.
// req_chan carries one item per transfer: mode 0 is a data byte (byte_in),
// mode 1 flushes the stream. rsp_chan carries one result per transfer:
// kind 0 is an output byte, kind 1 an invalid-sequence error (fatal mode),
// kind 2 the end-of-stream marker; last flags the final result of an item.
// Config is written through csr_we/csr_index/csr_wdata: index 0 fatal_mode,
// index 1 ignore_bom; write only while the block is idle.
// Throughput: one request per cycle while the two-entry result-list queue has
// room; the response side moves one result per cycle while the receiver is
// ready, so an item with N results takes N transfers and items with none take no slot.
// Each item's results are written into the queue at its transfer and reach
// the output register from the queue head once that register is free.
// Reset (synchronous, active high) clears the stream state, the queue, the
// output valid bit and both config bits. When the receiver stalls, the output
// register holds, the queue fills, and req_chan.ready drops once both queue
// entries are taken.
module utf8_validating_sanitizer import u8san_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic        csr_wdata,
   u8san_req_if.sink   req_chan,
   u8san_rsp_if.source rsp_chan
);

   logic    push_valid;
   logic    push_ready;
   cmd_type push_cmd;
   logic    head_valid;
   cmd_type head_cmd;
   logic    pop;

   u8san_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_chan   (req_chan),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .push_ready (push_ready)
   );

   u8san_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .push_ready (push_ready),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (pop)
   );

   u8san_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (pop),
      .rsp_chan   (rsp_chan)
   );

endmodule

[verif/testbench.sv]
// Self-checking testbench for the UTF-8 validating sanitizer: random and directed byte streams.
`timescale 1ns / 1ps

module testbench import u8san_pkg::*;;

   localparam logic MODE_DATA  = 1'b0;
   localparam logic MODE_FLUSH = 1'b1;
   localparam int   IDLE_PCT     = 35;
   localparam int   DRAIN_CYCLES = 8;
   localparam int   CYCLE_LIMIT  = 200000;

   typedef struct {
      logic       mode;
      logic [7:0] data;
   } stream_item_type;

   typedef struct {
      logic [1:0] kind;
      logic [7:0] data;
      logic       last;
   } out_result_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic csr_index;
   logic csr_wdata;

   u8san_req_if req_ch();
   u8san_rsp_if rsp_ch();

   utf8_validating_sanitizer u_top (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_chan  (req_ch),
      .rsp_chan  (rsp_ch)
   );

   stream_item_type pending_q[$];
   out_result_type  expected_q[$];
   out_result_type  step_q[$];
   int              items_queued;
   int              items_taken = 0;
   int              fail_count = 0;
   int              cycle_count = 0;
   bit              steady;

   // Predictor state
   logic       cfg_fatal;
   logic       cfg_keep_bom;
   logic [7:0] held[3] = '{8'h00, 8'h00, 8'h00};
   logic [1:0] held_cnt = 2'd0;
   logic [2:0] need_len = 3'd0;
   logic [2:0] range_sel = RANGE_ANY;
   logic       stream_start = 1'b1;
   logic       dropping = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor
   task automatic emit(input logic [1:0] k, input logic [7:0] d);
      out_result_type r;
      r.kind = k;
      r.data = d;
      r.last = 1'b0;
      step_q.push_back(r);
   endtask

   task automatic drop_partial();
      held_cnt  = 2'd0;
      need_len  = 3'd0;
      range_sel = RANGE_ANY;
   endtask

   task automatic flag_invalid();
      stream_start = 1'b0;
      drop_partial();
      if (cfg_fatal) begin
         emit(KIND_ERROR, 8'h00);
         dropping = 1'b1;
      end else begin
         emit(KIND_BYTE, REPL_0);
         emit(KIND_BYTE, REPL_1);
         emit(KIND_BYTE, REPL_2);
      end
   endtask

   task automatic start_sequence(input logic [7:0] b);
      if (b < ASCII_LIMIT) begin
         stream_start = 1'b0;
         emit(KIND_BYTE, b);
      end else if (b < LEAD_MIN || b >= LEAD_LIMIT) begin
         flag_invalid();
      end else begin
         held[0]  = b;
         held_cnt = 2'd1;
         if (b < LEAD3_MIN) begin
            need_len  = 3'd2;
            range_sel = RANGE_ANY;
         end else if (b < LEAD4_MIN) begin
            need_len  = 3'd3;
            range_sel = (b == LEAD_E0) ? RANGE_E0 : (b == LEAD_ED) ? RANGE_ED : RANGE_ANY;
         end else begin
            need_len  = 3'd4;
            range_sel = (b == LEAD_F0) ? RANGE_F0 : (b == LEAD_F4) ? RANGE_F4 : RANGE_ANY;
         end
      end
   endtask

   task automatic take_data(input logic [7:0] b);
      logic [7:0] lo, hi;
      int         i;
      if (dropping) return;
      if (held_cnt == 2'd0) begin
         start_sequence(b);
         return;
      end
      lo = 8'h80;
      hi = 8'hBF;
      if (held_cnt == 2'd1) begin
         case (range_sel)
            RANGE_E0: lo = 8'hA0;
            RANGE_ED: hi = 8'h9F;
            RANGE_F0: lo = 8'h90;
            RANGE_F4: hi = 8'h8F;
            default: ;
         endcase
      end
      if (b < lo || b > hi) begin
         // broken partial: replace it, then retry the byte as a new lead
         flag_invalid();
         if (!dropping) start_sequence(b);
         return;
      end
      if (held_cnt + 1 < need_len) begin
         held[held_cnt] = b;
         held_cnt       = held_cnt + 2'd1;
         return;
      end
      if (stream_start && !cfg_keep_bom && held_cnt == 2'd2 &&
          held[0] == BOM_0 && held[1] == BOM_1 && b == BOM_2) begin
         stream_start = 1'b0;
         drop_partial();
         return;
      end
      stream_start = 1'b0;
      for (i = 0; i < held_cnt; i++) emit(KIND_BYTE, held[i]);
      emit(KIND_BYTE, b);
      drop_partial();
   endtask

   task automatic close_stream();
      if (held_cnt != 2'd0 && !dropping) begin
         if (cfg_fatal) begin
            emit(KIND_ERROR, 8'h00);
         end else begin
            emit(KIND_BYTE, REPL_0);
            emit(KIND_BYTE, REPL_1);
            emit(KIND_BYTE, REPL_2);
         end
      end
      emit(KIND_END, 8'h00);
      drop_partial();
      stream_start = 1'b1;
      dropping     = 1'b0;
   endtask

   task automatic sanitize_item(input logic mode, input logic [7:0] b);
      step_q.delete();
      if (mode == MODE_FLUSH) close_stream();
      else take_data(b);
      if (step_q.size() > 0) step_q[$].last = 1'b1;
      foreach (step_q[i]) expected_q.push_back(step_q[i]);
   endtask

   // ---------------------------------------------------------------- driver
   always @(posedge clock) begin
      stream_item_type nxt;
      if (reset) begin
         req_ch.valid   <= 1'b0;
         req_ch.mode    <= MODE_DATA;
         req_ch.byte_in <= 8'h00;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            sanitize_item(req_ch.mode, req_ch.byte_in);
            items_taken++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (pending_q.size() > 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
               nxt = pending_q.pop_front();
               req_ch.valid   <= 1'b1;
               req_ch.mode    <= nxt.mode;
               req_ch.byte_in <= nxt.data;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------- monitor
   always @(posedge clock) begin
      out_result_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: unexpected result kind=%0d byte=%02h last=%0b", $realtime,
                           rsp_ch.kind, rsp_ch.byte_out, rsp_ch.last);
            end else begin
               want = expected_q.pop_front();
               if (rsp_ch.kind !== want.kind || rsp_ch.byte_out !== want.data ||
                   rsp_ch.last !== want.last) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display({"%0t: mismatch exp kind=%0d byte=%02h last=%0b, ",
                               "got kind=%0d byte=%02h last=%0b"},
                              $realtime, want.kind, want.data, want.last,
                              rsp_ch.kind, rsp_ch.byte_out, rsp_ch.last);
               end
            end
         end
         rsp_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("utf8_validating_sanitizer verification failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------- stimulus
   task automatic push_byte(input logic [7:0] b);
      stream_item_type it;
      it.mode = MODE_DATA;
      it.data = b;
      pending_q.push_back(it);
      items_queued++;
   endtask

   task automatic push_flush();
      stream_item_type it;
      it.mode = MODE_FLUSH;
      it.data = 8'($urandom_range(0, 255));
      pending_q.push_back(it);
      items_queued++;
   endtask

   // len 2..4; at position cut (if below len) the sequence either gets a bad byte or just stops
   task automatic push_seq(input int len, input int cut, input bit corrupt);
      logic [7:0] lead, lo, hi, b;
      int         i;
      case (len)
         2: lead = 8'($urandom_range(8'hC2, 8'hDF));
         3: case ($urandom_range(0, 3))
               0:       lead = LEAD_E0;
               1:       lead = LEAD_ED;
               default: lead = 8'($urandom_range(8'hE0, 8'hEF));
            endcase
         default: lead = 8'($urandom_range(8'hF0, 8'hF4));
      endcase
      push_byte(lead);
      for (i = 1; i < len; i++) begin
         lo = 8'h80;
         hi = 8'hBF;
         if (i == 1) begin
            if (lead == LEAD_E0) lo = 8'hA0;
            if (lead == LEAD_ED) hi = 8'h9F;
            if (lead == LEAD_F0) lo = 8'h90;
            if (lead == LEAD_F4) hi = 8'h8F;
         end
         if (i == cut) begin
            if (corrupt) begin
               do b = 8'($urandom_range(0, 255)); while (b >= lo && b <= hi);
               push_byte(b);
            end
            return;
         end
         push_byte(8'($urandom_range(lo, hi)));
      end
   endtask

   task automatic gen_stream();
      int units, u, pick, len;
      if ($urandom_range(0, 3) == 0) begin
         push_byte(BOM_0);
         push_byte(BOM_1);
         push_byte(BOM_2);
      end
      units = $urandom_range(1, 8);
      for (u = 0; u < units; u++) begin
         pick = $urandom_range(0, 99);
         len  = $urandom_range(2, 4);
         if (pick < 25) push_byte(8'($urandom_range(0, 127)));
         else if (pick < 70) push_seq(len, len, 1'b0);
         else if (pick < 80) push_byte(8'($urandom_range(0, 255)));
         else if (pick < 90) push_seq(len, $urandom_range(1, len - 1), 1'b1);
         else push_seq(len, $urandom_range(1, len - 1), 1'b0);
      end
      if ($urandom_range(0, 4) != 0) push_flush();
   endtask

   task automatic gen_random(input int count);
      int target;
      target = items_queued + count;
      while (items_queued < target) gen_stream();
   endtask

   task automatic wait_idle();
      while (!(items_taken == items_queued && expected_q.size() == 0)) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_cfg(input logic fatal, input logic keep_bom);
      wait_idle();
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_FATAL_MODE;
      csr_wdata <= fatal;
      @(posedge clock);
      cfg_fatal = fatal;
      csr_index <= CSR_IGNORE_BOM;
      csr_wdata <= keep_bom;
      @(posedge clock);
      cfg_keep_bom = keep_bom;
      csr_we <= 1'b0;
   endtask

   initial begin
      reset          = 1'b1;
      csr_we         = 1'b0;
      csr_index      = CSR_FATAL_MODE;
      csr_wdata      = 1'b0;
      items_queued   = 0;
      steady         = 1'b0;
      cfg_fatal      = 1'b0;
      cfg_keep_bom   = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // replacement mode, leading BOM dropped
      write_cfg(1'b0, 1'b0);
      push_byte(BOM_0); push_byte(BOM_1); push_byte(BOM_2);
      push_byte(8'h00); push_byte(8'h7F); push_byte(8'h80);
      push_byte(8'hC1); push_byte(8'hFF);
      push_byte(8'hC2); push_byte(8'h80);
      push_byte(8'hE0); push_byte(8'hA0); push_byte(8'h80);
      push_byte(8'hED); push_byte(8'hA0);
      push_byte(8'hF4); push_byte(8'h8F); push_byte(8'hBF); push_byte(8'hBF);
      push_byte(8'hF0); push_byte(8'h8F);
      push_byte(8'hE1); push_byte(8'h80); push_flush();
      push_flush();

      // fatal mode: error, drop until flush, partial at flush
      write_cfg(1'b1, 1'b0);
      push_byte(8'h80); push_byte(8'h41); push_flush();
      push_byte(8'hE1); push_flush();
      gen_random(100);

      // BOM kept, no idling on either side
      write_cfg(1'b0, 1'b1);
      steady = 1'b1;
      gen_random(120);
      wait_idle();
      steady = 1'b0;

      write_cfg(1'b1, 1'b1);
      gen_random(100);

      write_cfg(1'b0, 1'b0);
      gen_random(130);
      push_flush();

      wait_idle();
      if (fail_count == 0) begin
         $display("utf8_validating_sanitizer verification clean");
      end else begin
         $display("utf8_validating_sanitizer verification failed");
      end
      $finish;
   end

endmodule
